@@ design/ps2mpt_pkg.sv @@
`default_nettype none

package ps2mpt_pkg;

   // register map of the configuration port
   typedef enum logic [0:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned SizeWidth     = 13;
   localparam int unsigned PosWidth      = 12;
   localparam int unsigned ByteWidth     = 8;

   // header byte flags
   localparam int unsigned SyncBit  = 3;
   localparam int unsigned XSignBit = 4;
   localparam int unsigned YSignBit = 5;

   // screen margins taken off the size to get the cursor limit
   localparam logic [SizeWidth:0] XMargin = 14'd8;
   localparam logic [SizeWidth:0] YMargin = 14'd16;

   localparam logic [PosWidth-1:0]  HomePos        = 12'd500;
   localparam logic [SizeWidth-1:0] ResetWidth     = 13'd1024;
   localparam logic [SizeWidth-1:0] ResetHeight    = 13'd768;

   // what the motion unit needs for one packet
   typedef struct packed {
      logic [ByteWidth-1:0] header;
      logic [ByteWidth-1:0] x_delta;
      logic [ByteWidth-1:0] y_delta;
      logic [PosWidth-1:0]  pos_x;
      logic [PosWidth-1:0]  pos_y;
   } motion_in_type;

   typedef struct packed {
      logic [PosWidth-1:0] pos_x;
      logic [PosWidth-1:0] pos_y;
   } position_type;

endpackage

`default_nettype wire

@@ design/ps2mpt_motion.sv @@
`default_nettype none

module ps2mpt_motion (
   input  wire ps2mpt_pkg::motion_in_type                      motion_in,
   input  wire logic [ps2mpt_pkg::SizeWidth-1:0]               screen_width,
   input  wire logic [ps2mpt_pkg::SizeWidth-1:0]               screen_height,
   output ps2mpt_pkg::position_type                            position_out
);

   logic signed [ps2mpt_pkg::SizeWidth:0]  lim_x_raw;
   logic signed [ps2mpt_pkg::SizeWidth:0]  lim_y_raw;
   logic [ps2mpt_pkg::PosWidth-1:0]        lim_x;
   logic [ps2mpt_pkg::PosWidth-1:0]        lim_y;
   logic [ps2mpt_pkg::ByteWidth-1:0]       mag_x;
   logic [ps2mpt_pkg::ByteWidth-1:0]       mag_y;
   logic signed [ps2mpt_pkg::SizeWidth:0]  sum_x;
   logic signed [ps2mpt_pkg::SizeWidth:0]  sum_y;

   // cursor limits, floored at zero and saturated to the position range
   always_comb begin
      lim_x_raw = $signed({1'b0, screen_width} - ps2mpt_pkg::XMargin);
      lim_y_raw = $signed({1'b0, screen_height} - ps2mpt_pkg::YMargin);
      if (lim_x_raw < 0) begin
         lim_x = '0;
      end else if (lim_x_raw[ps2mpt_pkg::SizeWidth-1]) begin
         lim_x = '1;
      end else begin
         lim_x = lim_x_raw[ps2mpt_pkg::PosWidth-1:0];
      end
      if (lim_y_raw < 0) begin
         lim_y = '0;
      end else if (lim_y_raw[ps2mpt_pkg::SizeWidth-1]) begin
         lim_y = '1;
      end else begin
         lim_y = lim_y_raw[ps2mpt_pkg::PosWidth-1:0];
      end
   end

   // sign and magnitude movement: negative byte of zero moves nothing
   always_comb begin
      mag_x = 8'd0 - motion_in.x_delta;
      mag_y = 8'd0 - motion_in.y_delta;
      if (motion_in.header[ps2mpt_pkg::XSignBit]) begin
         sum_x = $signed({2'b00, motion_in.pos_x} - {6'd0, mag_x});
      end else begin
         sum_x = $signed({2'b00, motion_in.pos_x} + {6'd0, motion_in.x_delta});
      end
      // screen y points down
      if (motion_in.header[ps2mpt_pkg::YSignBit]) begin
         sum_y = $signed({2'b00, motion_in.pos_y} + {6'd0, mag_y});
      end else begin
         sum_y = $signed({2'b00, motion_in.pos_y} - {6'd0, motion_in.y_delta});
      end
   end

   // clamp into 0..limit
   always_comb begin
      if (sum_x < 0) begin
         position_out.pos_x = '0;
      end else if (sum_x > $signed({2'b00, lim_x})) begin
         position_out.pos_x = lim_x;
      end else begin
         position_out.pos_x = sum_x[ps2mpt_pkg::PosWidth-1:0];
      end
      if (sum_y < 0) begin
         position_out.pos_y = '0;
      end else if (sum_y > $signed({2'b00, lim_y})) begin
         position_out.pos_y = lim_y;
      end else begin
         position_out.pos_y = sum_y[ps2mpt_pkg::PosWidth-1:0];
      end
   end

endmodule

`default_nettype wire

@@ design/ps2_mouse_packet_tracker.sv @@
// a third packet byte passes the input register, then its cursor is registered and shown on rsp
// throughput: one byte per cycle; the input register drains whenever the result
// register is free or being taken in the same cycle
// reset: synchronous, active high; phase to header, cursor to 500,500,
// screen size to 1024 by 768; the configuration port is always ready
`default_nettype none

module ps2_mouse_packet_tracker (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic [ps2mpt_pkg::ByteWidth-1:0]        req_data_byte,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic [ps2mpt_pkg::PosWidth-1:0]              rsp_cursor_x,
   output logic [ps2mpt_pkg::PosWidth-1:0]              rsp_cursor_y,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [ps2mpt_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [ps2mpt_pkg::SizeWidth-1:0]        csr_data
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_X      = 2'd1,
      PH_Y      = 2'd2
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic [ps2mpt_pkg::ByteWidth-1:0]   header_ff, header_in;
   logic [ps2mpt_pkg::ByteWidth-1:0]   x_delta_ff, x_delta_in;
   logic [ps2mpt_pkg::PosWidth-1:0]    pos_x_ff, pos_y_ff;
   logic [ps2mpt_pkg::SizeWidth-1:0]   width_ff, height_ff;
   logic                               s1_valid_ff;
   logic [ps2mpt_pkg::ByteWidth-1:0]   s1_byte_ff;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic                               s1_is_y;
   logic                               s1_advance;
   logic                               req_fire;
   logic                               result_load;
   ps2mpt_pkg::motion_in_type          motion_in;
   ps2mpt_pkg::position_type           motion_out;

   // input register drains unless it holds a final byte and the result is blocked
   assign s1_is_y     = (phase_ff == PH_Y);
   assign s1_advance  = s1_valid_ff && !(s1_is_y && rsp_valid_ff && !rsp_ready);
   assign result_load = s1_advance && s1_is_y;
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign req_fire    = req_valid && req_ready;
   assign csr_ready   = 1'b1;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cursor_x = pos_x_ff;
   assign rsp_cursor_y = pos_y_ff;

   // packet assembly
   always_comb begin
      phase_in   = phase_ff;
      header_in  = header_ff;
      x_delta_in = x_delta_ff;
      if (s1_advance) begin
         unique case (phase_ff)
            PH_X: begin
               x_delta_in = s1_byte_ff;
               phase_in   = PH_Y;
            end
            PH_Y: begin
               phase_in = PH_HEADER;
            end
            default: begin
               // resynchronise on the sync bit
               if (s1_byte_ff[ps2mpt_pkg::SyncBit]) begin
                  header_in = s1_byte_ff;
                  phase_in  = PH_X;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
         endcase
      end
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign motion_in.header  = header_ff;
   assign motion_in.x_delta = x_delta_ff;
   assign motion_in.y_delta = s1_byte_ff;
   assign motion_in.pos_x   = pos_x_ff;
   assign motion_in.pos_y   = pos_y_ff;

   ps2mpt_motion u_motion (
      .motion_in     (motion_in),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .position_out  (motion_out)
   );

   // state, configuration and the item registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         header_ff    <= '0;
         x_delta_ff   <= '0;
         pos_x_ff     <= ps2mpt_pkg::HomePos;
         pos_y_ff     <= ps2mpt_pkg::HomePos;
         width_ff     <= ps2mpt_pkg::ResetWidth;
         height_ff    <= ps2mpt_pkg::ResetHeight;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         header_ff    <= header_in;
         x_delta_ff   <= x_delta_in;
         rsp_valid_ff <= rsp_valid_in;
         if (result_load) begin
            pos_x_ff <= motion_out.pos_x;
            pos_y_ff <= motion_out.pos_y;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ps2mpt_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_data;
               ps2mpt_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // byte register needs no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_data_byte;
      end
   end

   // a final byte never overwrites a result that is still waiting
   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_is_y && rsp_valid_ff && !rsp_ready) |-> !s1_advance)
      else $error("result overwritten while waiting");

   // a held byte stays put until it is processed
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_byte_ff)))
      else $error("input register lost a byte");

   // a new result always comes with the phase back at the header
   a_result_phase: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (phase_ff == PH_HEADER))
      else $error("result without packet completion");

   // the cursor only moves when a result is loaded
   a_cursor_moves_with_result: assert property (@(posedge clock) disable iff (reset)
      !result_load |=> ($stable(pos_x_ff) && $stable(pos_y_ff)))
      else $error("cursor moved without a result");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ps2mpt_pkg::*;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned RandomBytes = 1700;

   // packet phase codes of the tracker
   localparam logic [1:0] PhaseHeader = 2'd0;
   localparam logic [1:0] PhaseXDelta = 2'd1;
   localparam logic [1:0] PhaseYDelta = 2'd2;

   // cursor tracker model and store of expected cursor items
   class cursor_scoreboard;
      logic [SizeWidth-1:0] width_reg;
      logic [SizeWidth-1:0] height_reg;
      logic [1:0]           phase;
      logic [ByteWidth-1:0] header;
      logic [ByteWidth-1:0] x_delta;
      logic [PosWidth-1:0]  pos_x;
      logic [PosWidth-1:0]  pos_y;
      position_type         cursor_q[$];
      int unsigned          errors;

      function new();
         width_reg  = ResetWidth;
         height_reg = ResetHeight;
         phase      = PhaseHeader;
         header     = '0;
         x_delta    = '0;
         pos_x      = HomePos;
         pos_y      = HomePos;
         errors     = 0;
      endfunction

      function void set_size(csr_index_type idx, logic [SizeWidth-1:0] value);
         case (idx)
            CSR_SCREEN_WIDTH:  width_reg = value;
            CSR_SCREEN_HEIGHT: height_reg = value;
            default: ;
         endcase
      endfunction

      // size less margin, held within 0..4095
      function int cursor_limit(logic [SizeWidth-1:0] size, int margin);
         int lim;
         lim = int'(size) - margin;
         if (lim < 0) lim = 0;
         if (lim > 4095) lim = 4095;
         return lim;
      endfunction

      function int clamp(int v, int lim);
         if (v < 0) return 0;
         if (v > lim) return lim;
         return v;
      endfunction

      // one accepted byte; the third of a packet yields a cursor item
      function void note_byte(logic [ByteWidth-1:0] b);
         position_type cursor;
         logic [ByteWidth-1:0] mag;
         int x;
         int y;
         case (phase)
            PhaseXDelta: begin
               x_delta = b;
               phase   = PhaseYDelta;
            end
            PhaseYDelta: begin
               phase = PhaseHeader;
               x = int'(pos_x);
               y = int'(pos_y);
               // negative deltas take the 8-bit two's complement as magnitude
               if (header[XSignBit]) begin
                  mag = 8'd0 - x_delta;
                  x = x - int'(mag);
               end else begin
                  x = x + int'(x_delta);
               end
               if (header[YSignBit]) begin
                  mag = 8'd0 - b;
                  y = y + int'(mag);
               end else begin
                  y = y - int'(b);
               end
               x = clamp(x, cursor_limit(width_reg, int'(XMargin)));
               y = clamp(y, cursor_limit(height_reg, int'(YMargin)));
               pos_x = x[PosWidth-1:0];
               pos_y = y[PosWidth-1:0];
               cursor.pos_x = pos_x;
               cursor.pos_y = pos_y;
               cursor_q.push_back(cursor);
            end
            default: begin
               // header phase, and the unused code too: only sync bytes start a packet
               phase = PhaseHeader;
               if (b[SyncBit]) begin
                  header = b;
                  phase  = PhaseXDelta;
               end
            end
         endcase
      endfunction

      function void check_cursor(logic [PosWidth-1:0] x, logic [PosWidth-1:0] y);
         position_type want;
         if (cursor_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: cursor item with none expected: x=%0d y=%0d", $time, x, y);
            return;
         end
         want = cursor_q.pop_front();
         if (x !== want.pos_x || y !== want.pos_y) begin
            errors++;
            if (errors <= 10)
               $display("%0t: cursor mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                        $time, want.pos_x, want.pos_y, x, y);
         end
      endfunction

      function int pending();
         return cursor_q.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [ByteWidth-1:0]     req_data_byte;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [PosWidth-1:0]      rsp_cursor_x;
   logic [PosWidth-1:0]      rsp_cursor_y;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [SizeWidth-1:0]     csr_data;

   cursor_scoreboard board;
   int unsigned      cycle_count = 0;
   int unsigned      burst_left;

   ps2_mouse_packet_tracker dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cursor_x  (rsp_cursor_x),
      .rsp_cursor_y  (rsp_cursor_y),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // observe handshakes; results first as they always belong to older items
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_cursor(rsp_cursor_x, rsp_cursor_y);
         if (req_valid && req_ready) board.note_byte(req_data_byte);
         if (csr_valid && csr_ready) board.set_size(csr_index_type'(csr_index), csr_data);
      end
   end

   // receiver stall pattern, changing character with bits 10:9 of the cycle count
   always @(negedge clock) begin
      case (cycle_count[10:9])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= cycle_count[0];
      endcase
   end

   // present one byte and hold it until taken; called and returns at a falling edge
   task automatic push_byte(input logic [ByteWidth-1:0] b);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // send a byte, then either carry on with the burst or leave a gap
   task automatic feed(input logic [ByteWidth-1:0] b);
      int unsigned gap;
      push_byte(b);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         burst_left = $urandom_range(0, 30);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_packet(input logic [7:0] h, input logic [7:0] dx,
                              input logic [7:0] dy);
      feed(h);
      feed(dx);
      feed(dy);
   endtask

   // stop sending and wait until every cursor item is back and the pipe is empty
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [SizeWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic set_screen(input logic [SizeWidth-1:0] w, input logic [SizeWidth-1:0] h);
      csr_write(CSR_SCREEN_WIDTH, w);
      csr_write(CSR_SCREEN_HEIGHT, h);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // mostly well-formed packets with a drifting direction, some noise and broken packets
   task automatic random_traffic(input int unsigned count);
      int unsigned sent;
      int unsigned x_pref;
      int unsigned y_pref;
      int unsigned n;
      logic [7:0]  h;
      sent = 0;
      n = 0;
      x_pref = 0;
      y_pref = 0;
      while (sent < count) begin
         if (n % 20 == 0) begin
            x_pref = $urandom_range(0, 2);
            y_pref = $urandom_range(0, 2);
         end
         n++;
         h = 8'($urandom_range(0, 255)) | 8'h08;
         if (x_pref != 0 && $urandom_range(0, 4) != 0) h[XSignBit] = (x_pref == 2);
         if (y_pref != 0 && $urandom_range(0, 4) != 0) h[YSignBit] = (y_pref == 2);
         case ($urandom_range(0, 19))
            0: feed(8'($urandom_range(0, 255)));
            1: begin
               // packet cut short, the next header lands in its place
               feed(h);
               if ($urandom_range(0, 1)) feed(8'($urandom_range(0, 255)));
            end
            default: begin
               send_packet(h, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
               sent += 3;
            end
         endcase
      end
   endtask

   initial begin
      logic [SizeWidth-1:0] widths[8];
      logic [SizeWidth-1:0] heights[8];
      board         = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      burst_left    = 0;
      widths  = '{13'd8,  13'd4096, 13'd0, 13'd8191, 13'd15, 13'd640, 13'd0, 13'd0};
      heights = '{13'd16, 13'd4096, 13'd0, 13'd8191, 13'd31, 13'd480, 13'd0, 13'd0};
      widths[6]  = 13'($urandom_range(0, 8191));
      heights[6] = 13'($urandom_range(0, 8191));
      widths[7]  = 13'($urandom_range(8, 4096));
      heights[7] = 13'($urandom_range(16, 4096));

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part on the reset screen size
      feed(8'h00);                     // no sync bit, dropped
      feed(8'hF7);                     // all but the sync bit, dropped
      send_packet(8'h08, 8'h00, 8'h00); // still at home
      send_packet(8'h38, 8'h00, 8'h00); // negative zero deltas, no motion
      send_packet(8'hFF, 8'h80, 8'h80);
      send_packet(8'h08, 8'hFF, 8'hFF);
      send_packet(8'h18, 8'h01, 8'h01);
      send_packet(8'h18, 8'h01, 8'h00); // moves 255 to the left
      send_packet(8'h28, 8'h7F, 8'h01);
      drain();

      // screen sizes from degenerate to saturated, random traffic on each
      for (int i = 0; i < 8; i++) begin
         set_screen(widths[i], heights[i]);
         random_traffic(RandomBytes / 8);
         drain();
      end

      if (board.errors == 0 && board.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
